### rtl/bdac_pkg.sv
// ----------------------------------------------------------------------------
// bdac_pkg
// shared types and constants for the binary to decimal ascii core
// ----------------------------------------------------------------------------
package bdac_pkg;

  localparam int ValueW       = 64;
  localparam int NumDigits    = 20;
  localparam int DigitW       = 4;
  localparam int BcdW         = NumDigits * DigitW;
  localparam int CharW        = 6;
  localparam int BitsPerStep  = 4;
  localparam int StepsPerItem = ValueW / BitsPerStep;
  localparam int PosW         = $clog2(NumDigits);
  localparam int StepW        = $clog2(StepsPerItem);

  localparam logic [CharW-1:0] AsciiZero = 6'd48;
  localparam logic [CharW-1:0] AsciiNine = 6'd57;

  typedef logic [BcdW-1:0]  bcd_t;
  typedef logic [PosW-1:0]  pos_t;
  typedef logic [StepW-1:0] step_t;

  // one converted number: packed bcd digits and the place of its top digit
  typedef struct packed {
    bcd_t bcd;
    pos_t top;
  } entry_t;

endpackage

### rtl/bdac_front.sv
// ----------------------------------------------------------------------------
// bdac_front
// takes one value and turns it into bcd digits by shift-and-add-3,
// four bits a cycle, then hands the digits and top digit place to the queue
// ----------------------------------------------------------------------------
module bdac_front import bdac_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic [ValueW-1:0] value,
  input  logic              value_valid,
  output logic              value_stall,
  output entry_t            push_entry,
  output logic              push_valid,
  input  logic              push_stall
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BUSY,
    ST_DONE
  } state_t;

  localparam step_t StepLast = step_t'(StepsPerItem - 1);

  state_t            state;
  logic [ValueW-1:0] bin;
  logic [ValueW-1:0] bin_next;
  bcd_t              bcd;
  bcd_t              bcd_next;
  step_t             cnt;
  pos_t              top;

  always_comb begin
    bcd_next = bcd;
    for (int s = 0; s < BitsPerStep; s++) begin
      for (int d = 0; d < NumDigits; d++) begin
        if (bcd_next[d*DigitW +: DigitW] >= 4'd5) begin
          bcd_next[d*DigitW +: DigitW] = bcd_next[d*DigitW +: DigitW] + 4'd3;
        end
      end
      bcd_next = {bcd_next[BcdW-2:0], bin[ValueW-1-s]};
    end
    bin_next = bin << BitsPerStep;
  end

  // highest non-zero digit, zero when the value is zero
  always_comb begin
    top = '0;
    for (int d = 0; d < NumDigits; d++) begin
      if (bcd[d*DigitW +: DigitW] != '0) begin
        top = pos_t'(d);
      end
    end
  end

  assign value_stall = (state != ST_IDLE);
  assign push_valid  = (state == ST_DONE);
  assign push_entry  = '{bcd: bcd, top: top};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (value_valid) begin
            bin   <= value;
            bcd   <= '0;
            cnt   <= '0;
            state <= ST_BUSY;
          end
        end
        ST_BUSY: begin
          bin <= bin_next;
          bcd <= bcd_next;
          cnt <= cnt + 1'b1;
          if (cnt == StepLast) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!push_stall) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    value_valid && !value_stall |=> state == ST_BUSY && cnt == '0)
    else $error("accepted item did not start conversion");

endmodule

### rtl/bdac_queue.sv
// ----------------------------------------------------------------------------
// bdac_queue
// short fifo of converted numbers between the converter and the emitter
// ----------------------------------------------------------------------------
module bdac_queue import bdac_pkg::*; #(
  parameter int Depth = 2
) (
  input  logic   clk,
  input  logic   rst,
  input  entry_t push_entry,
  input  logic   push_valid,
  output logic   push_stall,
  output entry_t pop_entry,
  output logic   pop_valid,
  input  logic   pop_stall
);

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  entry_t          mem [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            push;
  logic            pop;

  assign push_stall = (count == CntFull);
  assign pop_valid  = (count != '0);
  assign pop_entry  = mem[rd_ptr];
  assign push       = push_valid && !push_stall;
  assign pop        = pop_valid && !pop_stall;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrLast) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrLast) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CntFull)
    else $error("queue count past depth");

endmodule

### rtl/bdac_back.sv
// ----------------------------------------------------------------------------
// bdac_back
// walks a converted number from its top digit down and sends one ascii
// character per cycle through an output register while it is not stalled
// ----------------------------------------------------------------------------
module bdac_back import bdac_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  entry_t           pop_entry,
  input  logic             pop_valid,
  output logic             pop_stall,
  output logic [CharW-1:0] digit_char,
  output logic             last_digit,
  output logic             digit_valid,
  input  logic             digit_stall
);

  logic        busy;
  bcd_t        bcd;
  pos_t        pos;
  logic        out_free;
  logic        emit;
  logic        at_last;
  logic        load;
  logic [DigitW-1:0] digit;

  assign out_free  = !digit_valid || !digit_stall;
  assign emit      = busy && out_free;
  assign at_last   = (pos == '0);
  assign load      = pop_valid && (!busy || (emit && at_last));
  assign pop_stall = !load;
  assign digit     = bcd[pos*DigitW +: DigitW];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b0;
      digit_valid <= 1'b0;
    end else begin
      if (out_free) begin
        digit_valid <= busy;
      end
      if (emit) begin
        digit_char <= AsciiZero + CharW'(digit);
        last_digit <= at_last;
      end
      if (load) begin
        bcd  <= pop_entry.bcd;
        pos  <= pop_entry.top;
        busy <= 1'b1;
      end else if (emit) begin
        pos <= pos - 1'b1;
        if (at_last) begin
          busy <= 1'b0;
        end
      end
    end
  end

  a_char_range: assert property (@(posedge clk) disable iff (rst)
    digit_valid |-> digit_char >= AsciiZero && digit_char <= AsciiNine)
    else $error("character outside decimal digits");

  a_more_digits: assert property (@(posedge clk) disable iff (rst)
    digit_valid && !digit_stall && !last_digit |-> busy)
    else $error("number ended without a last digit");

endmodule

### rtl/binary_to_decimal_ascii_core.sv
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii_core
// Converts an unsigned 64-bit value into its decimal ascii digits, most
// significant first, one character per output item, with leading zeros
// dropped and last_digit set on the final character. The converter accepts
// a value while idle, steps it through the shift-and-add-3 unit at four
// bits a cycle, then passes the digits to a small queue; it takes no new
// value until the queue has taken them. The emitter sends one character
// per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii_core import bdac_pkg::*; #(
  parameter int QueueDepth = 2
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [ValueW-1:0] value,
  input  logic              value_valid,
  output logic              value_stall,
  output logic [CharW-1:0]  digit_char,
  output logic              last_digit,
  output logic              digit_valid,
  input  logic              digit_stall
);

  entry_t push_entry;
  logic   push_valid;
  logic   push_stall;
  entry_t pop_entry;
  logic   pop_valid;
  logic   pop_stall;

  bdac_front u_front (
    .clk         (clk),
    .rst         (rst),
    .value       (value),
    .value_valid (value_valid),
    .value_stall (value_stall),
    .push_entry  (push_entry),
    .push_valid  (push_valid),
    .push_stall  (push_stall)
  );

  bdac_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_entry (push_entry),
    .push_valid (push_valid),
    .push_stall (push_stall),
    .pop_entry  (pop_entry),
    .pop_valid  (pop_valid),
    .pop_stall  (pop_stall)
  );

  bdac_back u_back (
    .clk         (clk),
    .rst         (rst),
    .pop_entry   (pop_entry),
    .pop_valid   (pop_valid),
    .pop_stall   (pop_stall),
    .digit_char  (digit_char),
    .last_digit  (last_digit),
    .digit_valid (digit_valid),
    .digit_stall (digit_stall)
  );

endmodule
